### rtl/leb_pkg.sv
// shared constants, codes and types of the line edit buffer
`default_nettype none

package leb_pkg;

    // line store geometry
    localparam int LINE_CAPACITY = 64;
    localparam int ADDR_W        = $clog2(LINE_CAPACITY);
    localparam int LEN_W         = 7;

    // beat field widths
    localparam int MODE_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // key kinds as they arrive on the key channel
    typedef enum logic [MODE_W-1:0] {
        MODE_LEFT      = 3'd0,
        MODE_RIGHT     = 3'd1,
        MODE_DELETE    = 3'd2,
        MODE_HOME      = 3'd3,
        MODE_END       = 3'd4,
        MODE_BACKSPACE = 3'd5,
        MODE_CHAR      = 3'd6,
        MODE_ENTER     = 3'd7
    } t_mode;

    // status codes of a status beat
    typedef enum logic [STATUS_W-1:0] {
        ST_APPLIED = 2'd0,
        ST_IGNORED = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // classified operations handed to the back end
    typedef enum logic [3:0] {
        OP_IGNORE,
        OP_LEFT,
        OP_RIGHT,
        OP_DELETE,
        OP_HOME,
        OP_END,
        OP_BACKSPACE,
        OP_CHAR,
        OP_ENTER
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic                kind;
        logic [CHAR_W-1:0]   char_value;
        logic                last;
        logic [LEN_W-1:0]    cursor_out;
        logic [LEN_W-1:0]    length_out;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

`default_nettype wire

### rtl/leb_if.sv
// key and result channel interfaces of the line edit buffer
`default_nettype none

interface leb_key_if;
    logic                        valid;
    logic                        ready;
    logic [leb_pkg::MODE_W-1:0]  mode;
    logic [leb_pkg::CHAR_W-1:0]  char_code;
    logic                        key_pressed;

    modport source (output valid, mode, char_code, key_pressed, input ready);
    modport sink   (input valid, mode, char_code, key_pressed, output ready);
endinterface

interface leb_res_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [leb_pkg::CHAR_W-1:0]    char_value;
    logic                          last;
    logic [leb_pkg::LEN_W-1:0]     cursor_out;
    logic [leb_pkg::LEN_W-1:0]     length_out;
    logic [leb_pkg::STATUS_W-1:0]  status;

    modport source (output valid, kind, char_value, last, cursor_out, length_out, status,
                    input ready);
    modport sink   (input valid, kind, char_value, last, cursor_out, length_out, status,
                    output ready);
endinterface

`default_nettype wire

### rtl/leb_front.sv
// front end: takes key beats and classifies them into commands
`default_nettype none

module leb_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    leb_key_if.sink        i_key,
    output logic           o_cmd_valid,
    output leb_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_ready
);

    logic          r_valid;
    leb_pkg::t_cmd r_cmd;
    leb_pkg::t_cmd n_cmd;
    logic          key_take;

    // one-entry stage, refilled as it drains
    assign i_key.ready = !r_valid || i_cmd_ready;
    assign key_take    = i_key.valid && i_key.ready;

    // classify the key: releases and empty characters do nothing
    always_comb begin
        n_cmd.ch = i_key.char_code;
        n_cmd.op = leb_pkg::OP_IGNORE;
        if (i_key.key_pressed) begin
            unique case (leb_pkg::t_mode'(i_key.mode))
                leb_pkg::MODE_LEFT:      n_cmd.op = leb_pkg::OP_LEFT;
                leb_pkg::MODE_RIGHT:     n_cmd.op = leb_pkg::OP_RIGHT;
                leb_pkg::MODE_DELETE:    n_cmd.op = leb_pkg::OP_DELETE;
                leb_pkg::MODE_HOME:      n_cmd.op = leb_pkg::OP_HOME;
                leb_pkg::MODE_END:       n_cmd.op = leb_pkg::OP_END;
                leb_pkg::MODE_BACKSPACE: n_cmd.op = leb_pkg::OP_BACKSPACE;
                leb_pkg::MODE_CHAR: begin
                    n_cmd.op = (i_key.char_code == '0) ? leb_pkg::OP_IGNORE
                                                       : leb_pkg::OP_CHAR;
                end
                leb_pkg::MODE_ENTER:     n_cmd.op = leb_pkg::OP_ENTER;
                default:                 n_cmd.op = leb_pkg::OP_IGNORE;
            endcase
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (key_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (key_take) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

### rtl/leb_fifo.sv
// short command queue between the front and back ends
`default_nettype none

module leb_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  leb_pkg::t_cmd  i_push_cmd,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output leb_pkg::t_cmd  o_pop_cmd,
    input  logic           i_pop_ready
);

    leb_pkg::t_cmd               r_mem [leb_pkg::QUEUE_DEPTH];
    logic [leb_pkg::QPTR_W-1:0]  r_wp;
    logic [leb_pkg::QPTR_W-1:0]  r_rp;
    logic [leb_pkg::QCNT_W-1:0]  r_count;
    logic                        push;
    logic                        pop;

    assign o_push_ready = (r_count != leb_pkg::QCNT_W'(leb_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == leb_pkg::QPTR_W'(leb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == leb_pkg::QPTR_W'(leb_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entries
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/leb_back.sv
// back end: line store, cursor, length and the shift and commit sequencer
`default_nettype none

module leb_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    input  leb_pkg::t_cmd  i_cmd,
    output logic           o_cmd_ready,
    leb_res_if.source      o_res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT,
        S_DONE,
        S_COMMIT
    } t_state;

    // line store
    logic [leb_pkg::CHAR_W-1:0] r_mem [leb_pkg::LINE_CAPACITY];
    logic [leb_pkg::CHAR_W-1:0] r_rd_data;

    t_state                       r_state,     n_state;
    logic [leb_pkg::LEN_W-1:0]    r_cur,       n_cur;
    logic [leb_pkg::LEN_W-1:0]    r_len,       n_len;
    logic [leb_pkg::LEN_W-1:0]    r_cnt,       n_cnt;
    logic [leb_pkg::ADDR_W-1:0]   r_src,       n_src;
    logic [leb_pkg::ADDR_W-1:0]   r_wr_addr,   n_wr_addr;
    logic                         r_up,        n_up;
    logic                         r_pend,      n_pend;
    logic                         r_pend_last, n_pend_last;
    leb_pkg::t_op                 r_op,        n_op;
    logic [leb_pkg::CHAR_W-1:0]   r_ch,        n_ch;
    logic                         r_out_valid, n_out_valid;
    leb_pkg::t_res                r_out,       n_out;

    logic                         out_free;
    logic                         cmd_pop;
    logic                         rd_issue;
    logic                         beat_load;
    logic                         shift_end;
    logic                         char_wr;
    logic                         mem_we;
    logic [leb_pkg::ADDR_W-1:0]   mem_waddr;
    logic [leb_pkg::CHAR_W-1:0]   mem_wdata;
    logic                         emit_st;
    leb_pkg::t_status             st;

    assign out_free    = !r_out_valid || o_res.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign cmd_pop     = o_cmd_ready && i_cmd_valid;
    assign beat_load   = (r_state == S_COMMIT) && r_pend && out_free;
    assign shift_end   = (r_state == S_SHIFT) && (r_cnt == '0) && !r_pend;
    assign char_wr     = shift_end && (r_op == leb_pkg::OP_CHAR);

    // one read a cycle; a commit read waits until the held character moves on
    always_comb begin
        unique case (r_state)
            S_SHIFT:  rd_issue = (r_cnt != '0);
            S_COMMIT: rd_issue = (r_cnt != '0) && (!r_pend || beat_load);
            default:  rd_issue = 1'b0;
        endcase
    end

    // write port: shifted entry, or the new character at the cursor
    assign mem_we    = ((r_state == S_SHIFT) && r_pend) || char_wr;
    assign mem_waddr = r_pend ? r_wr_addr : r_cur[leb_pkg::ADDR_W-1:0];
    assign mem_wdata = r_pend ? r_rd_data : r_ch;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_issue) begin
            r_rd_data <= r_mem[r_src];
        end
    end

    // sequencer next state
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_src       = r_src;
        n_wr_addr   = r_wr_addr;
        n_up        = r_up;
        n_pend      = r_pend;
        n_pend_last = r_pend_last;
        n_op        = r_op;
        n_ch        = r_ch;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        emit_st     = 1'b0;
        st          = leb_pkg::ST_APPLIED;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_pop) begin
                    n_op = i_cmd.op;
                    n_ch = i_cmd.ch;
                    unique case (i_cmd.op)
                        leb_pkg::OP_IGNORE: begin
                            emit_st = 1'b1;
                            st      = leb_pkg::ST_IGNORED;
                        end
                        leb_pkg::OP_LEFT: begin
                            emit_st = 1'b1;
                            if (r_cur != '0) begin
                                n_cur = r_cur - 1'b1;
                            end else begin
                                st = leb_pkg::ST_IGNORED;
                            end
                        end
                        leb_pkg::OP_RIGHT: begin
                            emit_st = 1'b1;
                            if (r_cur < r_len) begin
                                n_cur = r_cur + 1'b1;
                            end else begin
                                st = leb_pkg::ST_IGNORED;
                            end
                        end
                        leb_pkg::OP_HOME: begin
                            emit_st = 1'b1;
                            n_cur   = '0;
                        end
                        leb_pkg::OP_END: begin
                            emit_st = 1'b1;
                            n_cur   = r_len;
                        end
                        leb_pkg::OP_DELETE: begin
                            if (r_cur >= r_len) begin
                                emit_st = 1'b1;
                                st      = leb_pkg::ST_IGNORED;
                            end else begin
                                n_cnt   = r_len - r_cur - 1'b1;
                                n_src   = r_cur[leb_pkg::ADDR_W-1:0] + 1'b1;
                                n_up    = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        leb_pkg::OP_BACKSPACE: begin
                            if (r_cur == '0) begin
                                emit_st = 1'b1;
                                st      = leb_pkg::ST_IGNORED;
                            end else begin
                                n_cnt   = r_len - r_cur;
                                n_src   = r_cur[leb_pkg::ADDR_W-1:0];
                                n_up    = 1'b0;
                                n_state = S_SHIFT;
                            end
                        end
                        leb_pkg::OP_CHAR: begin
                            if (r_len == leb_pkg::LEN_W'(leb_pkg::LINE_CAPACITY)) begin
                                emit_st = 1'b1;
                                st      = leb_pkg::ST_FULL;
                            end else begin
                                n_cnt   = r_len - r_cur;
                                n_src   = r_len[leb_pkg::ADDR_W-1:0] - 1'b1;
                                n_up    = 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        leb_pkg::OP_ENTER: begin
                            n_cur = '0;
                            if (r_len == '0) begin
                                emit_st = 1'b1;
                            end else begin
                                n_cnt   = r_len;
                                n_src   = '0;
                                n_len   = '0;
                                n_state = S_COMMIT;
                            end
                        end
                        default: begin
                            emit_st = 1'b1;
                            st      = leb_pkg::ST_IGNORED;
                        end
                    endcase
                end
            end

            // move the tail one entry per cycle, read one ahead of the write
            S_SHIFT: begin
                n_pend = rd_issue;
                if (rd_issue) begin
                    n_src     = r_up ? r_src - 1'b1 : r_src + 1'b1;
                    n_wr_addr = r_up ? r_src + 1'b1 : r_src - 1'b1;
                    n_cnt     = r_cnt - 1'b1;
                end
                if (shift_end) begin
                    unique case (r_op)
                        leb_pkg::OP_DELETE: begin
                            n_len = r_len - 1'b1;
                        end
                        leb_pkg::OP_BACKSPACE: begin
                            n_cur = r_cur - 1'b1;
                            n_len = r_len - 1'b1;
                        end
                        leb_pkg::OP_CHAR: begin
                            n_cur = r_cur + 1'b1;
                            n_len = r_len + 1'b1;
                        end
                        default: begin
                            n_len = r_len;
                        end
                    endcase
                    n_state = S_DONE;
                end
            end

            // status beat after an edit
            S_DONE: begin
                if (out_free) begin
                    emit_st = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // stream the committed line, one character beat per cycle while the result sink takes them
            S_COMMIT: begin
                n_pend = rd_issue || (r_pend && !beat_load);
                if (rd_issue) begin
                    n_src       = r_src + 1'b1;
                    n_cnt       = r_cnt - 1'b1;
                    n_pend_last = (r_cnt == leb_pkg::LEN_W'(1));
                end
                if (beat_load) begin
                    n_out_valid      = 1'b1;
                    n_out.kind       = 1'b1;
                    n_out.char_value = r_rd_data;
                    n_out.last       = r_pend_last;
                    n_out.cursor_out = '0;
                    n_out.length_out = '0;
                    n_out.status     = leb_pkg::ST_APPLIED;
                end
                if ((r_cnt == '0) && !r_pend) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // status beat carries the state after the step
        if (emit_st) begin
            n_out_valid      = 1'b1;
            n_out.kind       = 1'b0;
            n_out.char_value = '0;
            n_out.last       = 1'b1;
            n_out.cursor_out = n_cur;
            n_out.length_out = n_len;
            n_out.status     = st;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_src       <= n_src;
        r_wr_addr   <= n_wr_addr;
        r_up        <= n_up;
        r_pend_last <= n_pend_last;
        r_op        <= n_op;
        r_ch        <= n_ch;
        r_out       <= n_out;
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.char_value = r_out.char_value;
    assign o_res.last       = r_out.last;
    assign o_res.cursor_out = r_out.cursor_out;
    assign o_res.length_out = r_out.length_out;
    assign o_res.status     = r_out.status;

    // cursor stays within the line
    a_cur_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= r_len)
        else $error("cursor beyond line length");

    // line never exceeds the store
    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= leb_pkg::LEN_W'(leb_pkg::LINE_CAPACITY))
        else $error("line length beyond capacity");

    // shift never reads and writes the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && r_pend && rd_issue) |-> (r_wr_addr != r_src))
        else $error("shift read and write collide");

    // a commit runs with the line already cleared
    a_commit_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COMMIT) |-> (r_len == '0 && r_cur == '0))
        else $error("commit with line not cleared");

    // a finished shift always reports its status next
    a_shift_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        shift_end |=> (r_state == S_DONE))
        else $error("shift did not finish into status");

endmodule

`default_nettype wire

### rtl/line_edit_buffer.sv
// top level of the line edit buffer
`default_nettype none

// Console line editor: one key beat in, one status beat out, or on enter with a
// non-empty line one character beat per stored character, the final one marked
// last. Cursor moves, home, end, releases and rejected keys present their status
// beat once the key has passed the front command register, the command queue and
// the back end's result register. Insert, delete and backspace move the tail of
// the line one entry per cycle through the single-write line memory, so their
// status beat is registered only after the last entry has moved. Enter presents
// the first character beat once it has been read from the line memory, and then
// streams one character per cycle, slowed only by the result sink. Keys are
// decoded and queued ahead of the editing engine, so up to three keys can be
// taken while an edit is still under way. The line memory is not cleared at
// reset; only entries inside the line are ever read.
module line_edit_buffer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    leb_key_if.sink   i_key,
    leb_res_if.source o_res
);

    logic          front_valid;
    leb_pkg::t_cmd front_cmd;
    logic          front_ready;
    logic          queue_valid;
    leb_pkg::t_cmd queue_cmd;
    logic          queue_ready;

    leb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (i_key),
        .o_cmd_valid (front_valid),
        .o_cmd       (front_cmd),
        .i_cmd_ready (front_ready)
    );

    leb_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_cmd   (front_cmd),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_cmd    (queue_cmd),
        .i_pop_ready  (queue_ready)
    );

    leb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (queue_cmd),
        .o_cmd_ready (queue_ready),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the line edit buffer
`timescale 1ns / 1ps
`default_nettype none

module tb;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    leb_key_if key_if ();
    leb_res_if res_if ();

    line_edit_buffer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (key_if),
        .o_res   (res_if)
    );

    // 100 MHz clock
    always #5 i_clk = ~i_clk;

    // shadow copy of the edited line
    logic [leb_pkg::CHAR_W-1:0] line_shadow [leb_pkg::LINE_CAPACITY];
    int                         cursor_shadow;
    int                         length_shadow;
    leb_pkg::t_res              awaited_beats [$];

    // random idling on each side
    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;

    // run statistics
    int mismatch_count  = 0;
    int keys_accepted   = 0;
    int beats_checked   = 0;
    int lines_committed = 0;
    int longest_line    = 0;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // queue one status beat with the current cursor and length
    function automatic void push_status(input leb_pkg::t_status st);
        leb_pkg::t_res beat;
        beat            = '0;
        beat.last       = 1'b1;
        beat.cursor_out = leb_pkg::LEN_W'(cursor_shadow);
        beat.length_out = leb_pkg::LEN_W'(length_shadow);
        beat.status     = st;
        awaited_beats.push_back(beat);
    endfunction

    // apply one accepted key to the shadow line and queue the beats it causes
    function automatic void edit_line(input leb_pkg::t_mode mode,
                                      input logic [leb_pkg::CHAR_W-1:0] ch,
                                      input logic pressed);
        leb_pkg::t_status st;
        leb_pkg::t_res    beat;
        st = leb_pkg::ST_APPLIED;
        if (!pressed) begin
            push_status(leb_pkg::ST_IGNORED);
            return;
        end
        case (mode)
            leb_pkg::MODE_LEFT: begin
                if (cursor_shadow > 0) cursor_shadow--;
                else st = leb_pkg::ST_IGNORED;
            end
            leb_pkg::MODE_RIGHT: begin
                if (cursor_shadow < length_shadow) cursor_shadow++;
                else st = leb_pkg::ST_IGNORED;
            end
            leb_pkg::MODE_DELETE: begin
                if (cursor_shadow >= length_shadow) begin
                    st = leb_pkg::ST_IGNORED;
                end else begin
                    for (int i = cursor_shadow; i + 1 < length_shadow; i++)
                        line_shadow[leb_pkg::ADDR_W'(i)] =
                            line_shadow[leb_pkg::ADDR_W'(i + 1)];
                    length_shadow--;
                end
            end
            leb_pkg::MODE_HOME: cursor_shadow = 0;
            leb_pkg::MODE_END:  cursor_shadow = length_shadow;
            leb_pkg::MODE_BACKSPACE: begin
                if (cursor_shadow == 0) begin
                    st = leb_pkg::ST_IGNORED;
                end else begin
                    for (int i = cursor_shadow - 1; i + 1 < length_shadow; i++)
                        line_shadow[leb_pkg::ADDR_W'(i)] =
                            line_shadow[leb_pkg::ADDR_W'(i + 1)];
                    cursor_shadow--;
                    length_shadow--;
                end
            end
            leb_pkg::MODE_CHAR: begin
                if (ch == '0) begin
                    st = leb_pkg::ST_IGNORED;
                end else if (length_shadow >= leb_pkg::LINE_CAPACITY) begin
                    st = leb_pkg::ST_FULL;
                end else begin
                    for (int i = length_shadow; i > cursor_shadow; i--)
                        line_shadow[leb_pkg::ADDR_W'(i)] =
                            line_shadow[leb_pkg::ADDR_W'(i - 1)];
                    line_shadow[leb_pkg::ADDR_W'(cursor_shadow)] = ch;
                    length_shadow++;
                    cursor_shadow++;
                end
            end
            default: begin
                // enter: stream a non-empty line, then clear it
                cursor_shadow = 0;
                if (length_shadow != 0) begin
                    for (int i = 0; i < length_shadow; i++) begin
                        beat            = '0;
                        beat.kind       = 1'b1;
                        beat.char_value = line_shadow[leb_pkg::ADDR_W'(i)];
                        beat.last       = (i + 1 == length_shadow);
                        awaited_beats.push_back(beat);
                    end
                    if (length_shadow > longest_line) longest_line = length_shadow;
                    lines_committed++;
                    length_shadow = 0;
                    return;
                end
            end
        endcase
        push_status(st);
    endfunction

    // key channel monitor
    always @(posedge i_clk) begin
        if (i_rst_n && key_if.valid && key_if.ready) begin
            edit_line(leb_pkg::t_mode'(key_if.mode), key_if.char_code,
                      key_if.key_pressed);
            keys_accepted++;
        end
    end

    // result sink: check accepted beats, then choose the next ready
    initial begin
        leb_pkg::t_res got;
        leb_pkg::t_res want;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.kind       = res_if.kind;
                got.char_value = res_if.char_value;
                got.last       = res_if.last;
                got.cursor_out = res_if.cursor_out;
                got.length_out = res_if.length_out;
                got.status     = res_if.status;
                beats_checked++;
                if (awaited_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat kind %0d char %02h",
                                              got.kind, got.char_value));
                end else begin
                    want = awaited_beats.pop_front();
                    if (got.kind !== want.kind || got.char_value !== want.char_value ||
                        got.last !== want.last || got.cursor_out !== want.cursor_out ||
                        got.length_out !== want.length_out || got.status !== want.status)
                        report_mismatch({
                            $sformatf("got k%0d c%02h l%0d cur%0d len%0d st%0d, ",
                                      got.kind, got.char_value, got.last,
                                      got.cursor_out, got.length_out, got.status),
                            $sformatf("want k%0d c%02h l%0d cur%0d len%0d st%0d",
                                      want.kind, want.char_value, want.last,
                                      want.cursor_out, want.length_out, want.status)});
                end
            end
            res_if.ready <= !(sink_idle_en && $urandom_range(0, 99) < 7);
        end
    end

    // drive one key beat and hold it until the block takes it
    task automatic send_key(input leb_pkg::t_mode mode,
                            input logic [leb_pkg::CHAR_W-1:0] ch,
                            input logic pressed);
        if (src_idle_en && $urandom_range(0, 99) < 7) begin
            key_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 60);
        end
        key_if.valid       <= 1'b1;
        key_if.mode        <= mode;
        key_if.char_code   <= ch;
        key_if.key_pressed <= pressed;
        do @(posedge i_clk); while (!key_if.ready);
    endtask

    // stop sending and wait for every awaited beat
    task automatic wait_drained();
        key_if.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_beats.size() != 0) @(posedge i_clk);
    endtask

    // random nonzero printable-or-not character
    function automatic logic [leb_pkg::CHAR_W-1:0] any_char();
        return leb_pkg::CHAR_W'($urandom_range(1, 255));
    endfunction

    // one random key, weighted toward editing a line and committing it
    task automatic send_random_key();
        int                         pick;
        logic [leb_pkg::CHAR_W-1:0] ch;
        pick = $urandom_range(0, 99);
        ch   = leb_pkg::CHAR_W'($urandom_range(0, 255));
        if (length_shadow > 40 && pick < 20) begin
            send_key(leb_pkg::MODE_ENTER, ch, 1'b1);
        end else if (pick < 40) begin
            if ($urandom_range(0, 19) == 0) ch = '0;
            else if (ch == '0) ch = any_char();
            send_key(leb_pkg::MODE_CHAR, ch, 1'b1);
        end else if (pick < 48) send_key(leb_pkg::MODE_LEFT, ch, 1'b1);
        else if (pick < 56) send_key(leb_pkg::MODE_RIGHT, ch, 1'b1);
        else if (pick < 63) send_key(leb_pkg::MODE_DELETE, ch, 1'b1);
        else if (pick < 68) send_key(leb_pkg::MODE_HOME, ch, 1'b1);
        else if (pick < 73) send_key(leb_pkg::MODE_END, ch, 1'b1);
        else if (pick < 83) send_key(leb_pkg::MODE_BACKSPACE, ch, 1'b1);
        else if (pick < 90) send_key(leb_pkg::MODE_ENTER, ch, 1'b1);
        else send_key(leb_pkg::t_mode'(leb_pkg::MODE_W'($urandom_range(0, 7))), ch, 1'b0);
    endtask

    // boundaries, every key kind and the ignored cases on a short line
    task automatic test_directed();
        send_key(leb_pkg::MODE_LEFT, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_RIGHT, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_DELETE, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_BACKSPACE, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_HOME, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_END, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_ENTER, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'hFF, 1'b0);
        send_key(leb_pkg::MODE_CHAR, 8'hFF, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h01, 1'b1);
        send_key(leb_pkg::MODE_LEFT, 8'hA5, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h61, 1'b1);
        send_key(leb_pkg::MODE_DELETE, 8'h5A, 1'b1);
        send_key(leb_pkg::MODE_RIGHT, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_BACKSPACE, 8'hFF, 1'b1);
        send_key(leb_pkg::MODE_HOME, 8'h7E, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h80, 1'b1);
        send_key(leb_pkg::MODE_END, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_RIGHT, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_ENTER, 8'h33, 1'b0);
        send_key(leb_pkg::MODE_ENTER, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_ENTER, 8'h00, 1'b1);
    endtask

    // fill the line to capacity with long tail shifts, overflow it, commit it
    task automatic test_full_line();
        while (length_shadow < leb_pkg::LINE_CAPACITY) begin
            if ($urandom_range(0, 4) == 0) send_key(leb_pkg::MODE_HOME, 8'h00, 1'b1);
            else if ($urandom_range(0, 4) == 0) send_key(leb_pkg::MODE_LEFT, 8'h00, 1'b1);
            send_key(leb_pkg::MODE_CHAR, any_char(), 1'b1);
        end
        send_key(leb_pkg::MODE_CHAR, any_char(), 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'hFF, 1'b1);
        send_key(leb_pkg::MODE_HOME, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_DELETE, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h7F, 1'b1);
        send_key(leb_pkg::MODE_END, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_BACKSPACE, 8'h00, 1'b1);
        send_key(leb_pkg::MODE_CHAR, 8'h40, 1'b1);
        wait_drained();
        send_key(leb_pkg::MODE_ENTER, 8'h00, 1'b1);
    endtask

    // random editing with idling on both sides
    task automatic test_random_edit(input int count);
        repeat (count) send_random_key();
    endtask

    // back-to-back keys and an always-ready sink
    task automatic test_burst(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (count) send_random_key();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // main sequence
    initial begin
        key_if.valid       <= 1'b0;
        key_if.mode        <= leb_pkg::MODE_LEFT;
        key_if.char_code   <= '0;
        key_if.key_pressed <= 1'b0;
        cursor_shadow = 0;
        length_shadow = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_line();
        wait_drained();
        test_random_edit(80);
        test_burst(40);
        test_random_edit(20);

        wait_drained();
        repeat (100) @(posedge i_clk);
        while (awaited_beats.size() != 0) begin
            void'(awaited_beats.pop_front());
            report_mismatch("awaited beat never arrived");
        end

        $display("covered %0d keys and %0d result beats, %0d lines committed, longest %0d",
                 keys_accepted, beats_checked, lines_committed, longest_line);
        $display("mismatches seen: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("timeout with %0d beats still awaited", awaited_beats.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
